// ----- design/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants for the scalar Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  // Field widths fixed by the interface.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int TS_W       = 24;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_EST   = 3'd0,
    REG_INIT_COV   = 3'd1,
    REG_PROC_NOISE = 3'd2,
    REG_MEAS_NOISE = 3'd3,
    REG_TIME_STEP  = 3'd4
  } skf_reg_t;

  // Register values after reset.
  localparam logic [CFG_DATA_W-1:0] INIT_EST_RST   = 32'd0;
  localparam logic [CFG_DATA_W-1:0] INIT_COV_RST   = 32'd65536;
  localparam logic [CFG_DATA_W-1:0] PROC_NOISE_RST = 32'd6554;
  localparam logic [CFG_DATA_W-1:0] MEAS_NOISE_RST = 32'd262144;
  localparam logic [TS_W-1:0]       TIME_STEP_RST  = 24'd65536;

  // Control of a serial arithmetic unit.
  typedef struct packed {
    logic load;
    logic step;
  } skf_ctrl_t;

endpackage

`default_nettype wire

// ----- design/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional fixed-point Kalman filter, one predict and update per beat.
//
// The arithmetic is done by four bit-serial units: the velocity times
// time_step multiplier, which walks the 24 time_step bits and runs alongside
// the restoring gain divider, followed by the two gain multipliers for
// estimate and covariance, which run together over the FRAC_BITS+1 gain bits.
// One item is in flight at a time; a new beat is accepted while the previous
// result still waits in the output register. Every register write, and reset,
// reloads the estimate and covariance from the initial values in the
// following cycle, during which no beat is accepted; a result stored in that
// cycle overrides the reload.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [skf_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [skf_pkg::IN_W-1:0]   rate_of_change,
  input  logic signed [skf_pkg::IN_W-1:0]   measured_value,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [skf_pkg::OUT_W-1:0]  estimate_out,
  output logic        [skf_pkg::OUT_W-1:0]  covariance_out,
  output logic        [FRAC_BITS:0]         gain_out,
  output logic                              saturated
);

  import skf_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int GW   = F + 1;
  localparam int VPW  = IN_W + TS_W;
  localparam int VSW  = VPW - F;
  localparam int XW   = ((W > VSW) ? W : VSW) + 1;
  localparam int WW   = ((W > CFG_DATA_W) ? W : CFG_DATA_W) + 1;
  localparam int CPW  = WW + GW;
  localparam int CSW  = CPW - F;
  localparam int X2W  = CSW + 1;
  localparam int PPW  = W + 1 + GW;
  localparam int RUN1 = (TS_W > GW) ? TS_W : GW;
  localparam int CNTW = $clog2(RUN1 + 1);

  localparam logic [GW-1:0]       GAIN_ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [W-1:0] EST_MAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] EST_MIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]        COV_MAX  = {W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN1,
    S_X1,
    S_LOAD2,
    S_RUN2,
    S_DONE
  } state_t;

  state_t state;
  logic [CNTW-1:0] cnt;
  logic            reload;

  // Configuration registers.
  logic signed [CFG_DATA_W-1:0] init_est;
  logic [CFG_DATA_W-1:0]        init_cov;
  logic [CFG_DATA_W-1:0]        proc_noise;
  logic [CFG_DATA_W-1:0]        meas_noise;
  logic [TS_W-1:0]              time_step;

  // Filter state and per-item working registers.
  logic signed [W-1:0]    est;
  logic [W-1:0]           cov;
  logic signed [IN_W-1:0] meas;
  logic [W-1:0]           p1;
  logic                   den_zero;
  logic                   sat_acc;
  logic signed [W-1:0]    x1;
  logic [GW-1:0]          gain;

  logic in_accept;
  logic out_free;

  skf_ctrl_t vel_ctrl, div_ctrl, upd_ctrl;

  logic signed [VPW-1:0] vel_prod;
  logic [GW-1:0]         quot;
  logic signed [CPW-1:0] corr_prod;
  logic signed [PPW-1:0] cov_prod;

  // Combinational datapath pieces.
  logic signed [WW-1:0]  ld_est_ext;
  logic [WW-1:0]         ld_cov_ext;
  logic signed [W-1:0]   ld_est;
  logic [W-1:0]          ld_cov;
  logic [WW-1:0]         p1_sum;
  logic                  p1_fits;
  logic [WW-1:0]         den;
  logic signed [VSW-1:0] vel_scaled;
  logic signed [XW-1:0]  x1_sum;
  logic                  x1_fits;
  logic signed [WW-1:0]  innov;
  logic [GW-1:0]         keep;
  logic signed [CSW-1:0] corr;
  logic signed [X2W-1:0] x2_sum;
  logic                  x2_fits;
  logic signed [W-1:0]   x2;
  logic [W-1:0]          p2;
  logic signed [WW-1:0]  x2_ext;
  logic [WW-1:0]         p2_ext;

  assign in_stall  = (state != S_IDLE) || reload;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    // Initial values, clipped to the state width.
    ld_est_ext = WW'(init_est);
    ld_cov_ext = WW'(init_cov);
    if ((&ld_est_ext[WW-1:W-1]) || !(|ld_est_ext[WW-1:W-1])) begin
      ld_est = ld_est_ext[W-1:0];
    end else begin
      ld_est = ld_est_ext[WW-1] ? EST_MIN : EST_MAX;
    end
    ld_cov = (|ld_cov_ext[WW-1:W]) ? COV_MAX : ld_cov_ext[W-1:0];

    // Predicted covariance.
    p1_sum  = WW'(cov) + WW'(proc_noise);
    p1_fits = !(|p1_sum[WW-1:W]);
    den     = WW'(p1) + WW'(meas_noise);

    // Predicted estimate from the floored velocity product.
    vel_scaled = vel_prod[VPW-1:F];
    x1_sum     = XW'(est) + XW'(vel_scaled);
    x1_fits    = (&x1_sum[XW-1:W-1]) || !(|x1_sum[XW-1:W-1]);

    innov = WW'(meas) - WW'(x1);
    keep  = GAIN_ONE - gain;

    // Corrected estimate and shrunk covariance.
    corr    = corr_prod[CPW-1:F];
    x2_sum  = X2W'(x1) + X2W'(corr);
    x2_fits = (&x2_sum[X2W-1:W-1]) || !(|x2_sum[X2W-1:W-1]);
    if (x2_fits) begin
      x2 = x2_sum[W-1:0];
    end else begin
      x2 = x2_sum[X2W-1] ? EST_MIN : EST_MAX;
    end
    p2 = cov_prod[F+W-1:F];

    x2_ext = WW'(x2);
    p2_ext = WW'(p2);
  end

  always_comb begin
    vel_ctrl.load = in_accept;
    vel_ctrl.step = (state == S_RUN1) && (cnt < CNTW'(TS_W));
    div_ctrl.load = (state == S_LOAD);
    div_ctrl.step = (state == S_RUN1) && (cnt < CNTW'(GW));
    upd_ctrl.load = (state == S_LOAD2);
    upd_ctrl.step = (state == S_RUN2);
  end

  skf_mul #(.AW(IN_W), .BW(TS_W)) u_mul_vel (
    .clk     (clk),
    .ctrl    (vel_ctrl),
    .a       (rate_of_change),
    .b       (time_step),
    .product (vel_prod)
  );

  skf_div #(.DW(WW), .QW(GW)) u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .num      (WW'(p1)),
    .den      (den),
    .quotient (quot)
  );

  skf_mul #(.AW(WW), .BW(GW)) u_mul_est (
    .clk     (clk),
    .ctrl    (upd_ctrl),
    .a       (innov),
    .b       (gain),
    .product (corr_prod)
  );

  skf_mul #(.AW(W + 1), .BW(GW)) u_mul_cov (
    .clk     (clk),
    .ctrl    (upd_ctrl),
    .a       ($signed({1'b0, p1})),
    .b       (keep),
    .product (cov_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      reload     <= 1'b1;
      out_valid  <= 1'b0;
      init_est   <= INIT_EST_RST;
      init_cov   <= INIT_COV_RST;
      proc_noise <= PROC_NOISE_RST;
      meas_noise <= MEAS_NOISE_RST;
      time_step  <= TIME_STEP_RST;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (reload) begin
        est    <= ld_est;
        cov    <= ld_cov;
        reload <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            meas    <= measured_value;
            p1      <= p1_fits ? p1_sum[W-1:0] : COV_MAX;
            sat_acc <= !p1_fits;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          den_zero <= (den == '0);
          cnt      <= '0;
          state    <= S_RUN1;
        end
        S_RUN1: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(RUN1 - 1)) begin
            state <= S_X1;
          end
        end
        S_X1: begin
          if (x1_fits) begin
            x1 <= x1_sum[W-1:0];
          end else begin
            x1 <= x1_sum[XW-1] ? EST_MIN : EST_MAX;
          end
          sat_acc <= sat_acc || !x1_fits;
          gain    <= den_zero ? '0 : quot;
          state   <= S_LOAD2;
        end
        S_LOAD2: begin
          cnt   <= '0;
          state <= S_RUN2;
        end
        S_RUN2: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(GW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            est            <= x2;
            cov            <= p2;
            estimate_out   <= x2_ext[OUT_W-1:0];
            covariance_out <= p2_ext[OUT_W-1:0];
            gain_out       <= gain;
            saturated      <= sat_acc || !x2_fits;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Register writes come last so that a write always leaves a reload
      // pending.
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_EST: begin
            init_est <= cfg_data;
            reload   <= 1'b1;
          end
          REG_INIT_COV: begin
            init_cov <= cfg_data;
            reload   <= 1'b1;
          end
          REG_PROC_NOISE: begin
            proc_noise <= cfg_data;
            reload     <= 1'b1;
          end
          REG_MEAS_NOISE: begin
            meas_noise <= cfg_data;
            reload     <= 1'b1;
          end
          REG_TIME_STEP: begin
            time_step <= cfg_data[TS_W-1:0];
            reload    <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // An accepted beat always starts the divider load next.
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == S_LOAD)
    else $error("accepted beat did not start the divider load");

  // The gain never exceeds one.
  assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD2 |-> gain <= GAIN_ONE)
    else $error("gain above one");

  // A zero divisor yields a zero gain.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD2) && den_zero |-> gain == '0)
    else $error("zero divisor gave a nonzero gain");

  // The updated covariance never exceeds the predicted one.
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> p2 <= p1)
    else $error("covariance grew in the update");

  // A new result only appears at the end of an item.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result appeared outside the final step");

endmodule

`default_nettype wire

// ----- design/skf_mul.sv -----
// ----------------------------------------------------------------------------
// skf_mul
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier
// shifted out MSB first, one multiplier bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul #(
  parameter int AW = 32,
  parameter int BW = 24
) (
  input  logic                    clk,
  input  skf_pkg::skf_ctrl_t      ctrl,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic signed [AW+BW-1:0] product
);

  import skf_pkg::*;

  localparam int PW = AW + BW;

  logic signed [AW-1:0] a_reg;
  logic        [BW-1:0] b_sh;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] addend;

  assign addend  = b_sh[BW-1] ? PW'(a_reg) : '0;
  assign product = acc;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_reg <= a;
      b_sh  <= b;
      acc   <= '0;
    end else if (ctrl.step) begin
      acc  <= (acc <<< 1) + addend;
      b_sh <= {b_sh[BW-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ----- design/skf_div.sv -----
// ----------------------------------------------------------------------------
// skf_div
// Restoring divider, one quotient bit per step, quotient shifted in LSB last.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div #(
  parameter int DW = 33,
  parameter int QW = 17
) (
  input  logic               clk,
  input  skf_pkg::skf_ctrl_t ctrl,
  input  logic [DW-1:0]      num,
  input  logic [DW-1:0]      den,
  output logic [QW-1:0]      quotient
);

  import skf_pkg::*;

  logic [DW:0]   rem;
  logic [DW-1:0] den_reg;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_after;

  // The numerator never exceeds the divisor, so the remainder stays below
  // twice the divisor and fits one bit more than the divisor.
  assign ge        = rem >= {1'b0, den_reg};
  assign diff      = rem - {1'b0, den_reg};
  assign rem_after = ge ? diff[DW-1:0] : rem[DW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem      <= {1'b0, num};
      den_reg  <= den;
      quotient <= '0;
    end else if (ctrl.step) begin
      rem      <= {rem_after, 1'b0};
      quotient <= {quotient[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire
